// File: src/tangent_frame_from_three_points_defines.svh
`ifndef TANGENT_FRAME_FROM_THREE_POINTS_DEFINES_SVH
`define TANGENT_FRAME_FROM_THREE_POINTS_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TFP_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TFP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/tfp_pkg.sv
`default_nettype none
package tfp_pkg;

	// output component width
	localparam int OUT_W = 16;

	// normalized magnitudes sit in [2^23, 2^24)
	localparam int NORM_W = 24;
	// sum of three squares of NORM_W-bit values
	localparam int SUM_W = 50;
	localparam int ROOT_W = 25;
	localparam int REM_W = 26;

	localparam int CROSS_LAT = 4;

	// register stages from a unit-vector input to its registered result
	function automatic int unit_lat(input int frac);
		return frac + 34;
	endfunction

endpackage
`default_nettype wire

// File: src/tfp_unit3.sv
`default_nettype none
module tfp_unit3 #(
	parameter int IN_W = 33,
	parameter int FRAC = 14
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [IN_W-1:0] vec [3],
	output logic signed [FRAC+1:0] uvec [3],
	output logic                   zero
);
	localparam int NW = tfp_pkg::NORM_W;
	localparam int SW = tfp_pkg::SUM_W;
	localparam int RTW = tfp_pkg::ROOT_W;
	localparam int RMW = tfp_pkg::REM_W;
	localparam int QW = FRAC + 1;
	localparam int BLW = $clog2(IN_W + 1);
	localparam int NUMW = NW + FRAC + 1;

	typedef struct packed {
		logic [2:0] neg;
		logic       zero;
	} meta_t;

	typedef struct packed {
		logic [RMW-1:0] rem;
		logic [RTW-1:0] root;
	} rt_t;

	typedef struct packed {
		logic [RTW-1:0] rem;
		logic [QW-1:0]  low;
		logic [QW-1:0]  quo;
	} dv_t;

	// one digit of the square root: two radicand bits in, one root bit out
	function automatic rt_t rt_step(input rt_t s, input logic [1:0] pair);
		logic [RMW+1:0] cur;
		logic [RMW+1:0] trial;
		rt_t o;
		cur = {s.rem, pair};
		trial = (RMW+2)'({s.root, 2'b01});
		if (cur >= trial) begin
			o.rem = RMW'(cur - trial);
			o.root = {s.root[RTW-2:0], 1'b1};
		end else begin
			o.rem = RMW'(cur);
			o.root = {s.root[RTW-2:0], 1'b0};
		end
		return o;
	endfunction

	// one restoring division step
	function automatic dv_t dv_step(input dv_t s, input logic [RTW-1:0] len);
		logic [RTW:0] t;
		dv_t o;
		t = {s.rem, s.low[QW-1]};
		o.low = {s.low[QW-2:0], 1'b0};
		if (t >= {1'b0, len}) begin
			o.rem = RTW'(t - {1'b0, len});
			o.quo = {s.quo[QW-2:0], 1'b1};
		end else begin
			o.rem = RTW'(t);
			o.quo = {s.quo[QW-2:0], 1'b0};
		end
		return o;
	endfunction

	logic [2:0][IN_W-1:0] mag_s1, mag_s2, mag_s3;
	logic [2:0]           neg_s1, neg_s2, neg_s3;
	logic [IN_W-1:0]      max_c, max_s2;
	logic [BLW-1:0]       bl_c, bl_s3;
	logic                 zero_s3;
	logic [2:0][NW-1:0]   nm_s4, nm_s5;
	meta_t                meta_s4, meta_s5;
	logic [2:0][2*NW-1:0] sq_s5;

	logic [SW-1:0]        rad_s [0:RTW-1];
	rt_t                  rt_s [0:RTW];
	logic [2:0][NW-1:0]   nm_rt_s [0:RTW];
	meta_t                meta_rt_s [0:RTW];

	logic [NUMW-1:0]      num_c [3];
	dv_t                  dv_s [0:QW][3];
	logic [RTW-1:0]       len_s [0:QW-1];
	meta_t                meta_dv_s [0:QW];

	logic signed [FRAC+1:0] uvec_q [3];
	logic                   zero_q;

	always_comb begin
		max_c = mag_s1[0];
		if (mag_s1[1] > max_c) max_c = mag_s1[1];
		if (mag_s1[2] > max_c) max_c = mag_s1[2];
	end

	// bit length of the largest magnitude
	always_comb begin
		bl_c = '0;
		for (int i = 0; i < IN_W; i++) begin
			if (max_s2[i]) bl_c = BLW'(i + 1);
		end
	end

	// scaled magnitude plus half the length, for round to nearest
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = NUMW'({nm_rt_s[RTW][i], {FRAC{1'b0}}}) + NUMW'(rt_s[RTW].root >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec[i][IN_W-1];
				mag_s1[i] <= vec[i][IN_W-1] ? unsigned'(-vec[i]) : unsigned'(vec[i]);
			end
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			max_s2 <= max_c;

			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			bl_s3 <= bl_c;
			zero_s3 <= (max_s2 == '0);

			// one shift puts the largest magnitude into [2^23, 2^24)
			for (int i = 0; i < 3; i++) begin
				nm_s4[i] <= NW'({mag_s3[i], {NW{1'b0}}} >> bl_s3);
			end
			meta_s4 <= '{neg: neg_s3, zero: zero_s3};

			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= nm_s4[i] * nm_s4[i];
			end
			nm_s5 <= nm_s4;
			meta_s5 <= meta_s4;

			rad_s[0] <= SW'(sq_s5[0]) + SW'(sq_s5[1]) + SW'(sq_s5[2]);
			rt_s[0] <= '0;
			nm_rt_s[0] <= nm_s5;
			meta_rt_s[0] <= meta_s5;

			for (int k = 0; k < RTW; k++) begin
				rt_s[k+1] <= rt_step(rt_s[k], rad_s[k][SW-1 -: 2]);
				nm_rt_s[k+1] <= nm_rt_s[k];
				meta_rt_s[k+1] <= meta_rt_s[k];
				if (k < RTW - 1) begin
					rad_s[k+1] <= rad_s[k] << 2;
				end
			end

			len_s[0] <= rt_s[RTW].root;
			meta_dv_s[0] <= meta_rt_s[RTW];
			for (int i = 0; i < 3; i++) begin
				dv_s[0][i] <= '{rem: RTW'(num_c[i] >> QW), low: num_c[i][QW-1:0], quo: '0};
			end

			for (int j = 0; j < QW; j++) begin
				for (int i = 0; i < 3; i++) begin
					dv_s[j+1][i] <= dv_step(dv_s[j][i], len_s[j]);
				end
				meta_dv_s[j+1] <= meta_dv_s[j];
				if (j < QW - 1) begin
					len_s[j+1] <= len_s[j];
				end
			end

			for (int i = 0; i < 3; i++) begin
				uvec_q[i] <= meta_dv_s[QW].neg[i] ? -$signed({1'b0, dv_s[QW][i].quo})
					: $signed({1'b0, dv_s[QW][i].quo});
			end
			zero_q <= meta_dv_s[QW].zero;
		end
	end

	assign uvec = uvec_q;
	assign zero = zero_q;

endmodule
`default_nettype wire

// File: src/tfp_cross.sv
`default_nettype none
module tfp_cross #(
	parameter int FRAC = 14
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [FRAC+1:0] a [3],
	input  logic signed [FRAC+1:0] b [3],
	output logic signed [FRAC+1:0] o [3]
);
	localparam int CWD = FRAC + 2;
	localparam int PW = 2 * CWD;
	localparam int DW = PW + 1;
	localparam logic [DW:0] HALF = (DW+1)'(1) << (FRAC - 1);
	localparam logic [DW:0] ONE = (DW+1)'(1) << FRAC;

	logic signed [PW-1:0]  prod_s1 [6];
	logic signed [DW-1:0]  diff_s2 [3];
	logic [DW-1:0]         mag_s3 [3];
	logic [2:0]            neg_s3;
	logic [DW:0]           rnd_c [3];
	logic [FRAC:0]         clip_c [3];
	logic signed [CWD-1:0] res_s4 [3];

	// round half away from zero, then clamp to one
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd_c[i] = ({1'b0, mag_s3[i]} + HALF) >> FRAC;
			clip_c[i] = (rnd_c[i] > ONE) ? ONE[FRAC:0] : rnd_c[i][FRAC:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[0] <= a[1] * b[2];
			prod_s1[1] <= a[2] * b[1];
			prod_s1[2] <= a[2] * b[0];
			prod_s1[3] <= a[0] * b[2];
			prod_s1[4] <= a[0] * b[1];
			prod_s1[5] <= a[1] * b[0];
			for (int i = 0; i < 3; i++) begin
				diff_s2[i] <= DW'(prod_s1[2*i]) - DW'(prod_s1[2*i+1]);
				neg_s3[i] <= diff_s2[i][DW-1];
				mag_s3[i] <= diff_s2[i][DW-1] ? unsigned'(-diff_s2[i]) : unsigned'(diff_s2[i]);
				res_s4[i] <= neg_s3[i] ? -$signed({1'b0, clip_c[i]}) : $signed({1'b0, clip_c[i]});
			end
		end
	end

	assign o = res_s4;

endmodule
`default_nettype wire

// File: src/tangent_frame_from_three_points.sv
// channel  direction  handshake            payload
// in       sink       in_valid / in_stall    p1_*, p2_*, p3_* (COORD_WIDTH, Q16.16)
// out      source     out_valid / out_stall  tan_*, bin_*, nrm_* (16-bit Q1.14), degenerate
//
// one transaction per cycle in each direction while the pipeline is not held
// the pipeline depth comes mostly from the chained unit-vector pipelines (a 25-step root, a FRAC_BITS+1-step divide)
// the whole pipeline advances together; it holds only while out_valid is high and out_stall is
// high, and in_stall follows that condition
// arst_n clears the valid bits only; data registers carry no reset
`default_nettype none
module tangent_frame_from_three_points #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [COORD_WIDTH-1:0]       p1_x,
	input  logic signed [COORD_WIDTH-1:0]       p1_y,
	input  logic signed [COORD_WIDTH-1:0]       p1_z,
	input  logic signed [COORD_WIDTH-1:0]       p2_x,
	input  logic signed [COORD_WIDTH-1:0]       p2_y,
	input  logic signed [COORD_WIDTH-1:0]       p2_z,
	input  logic signed [COORD_WIDTH-1:0]       p3_x,
	input  logic signed [COORD_WIDTH-1:0]       p3_y,
	input  logic signed [COORD_WIDTH-1:0]       p3_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [tfp_pkg::OUT_W-1:0]    tan_x,
	output logic signed [tfp_pkg::OUT_W-1:0]    tan_y,
	output logic signed [tfp_pkg::OUT_W-1:0]    tan_z,
	output logic signed [tfp_pkg::OUT_W-1:0]    bin_x,
	output logic signed [tfp_pkg::OUT_W-1:0]    bin_y,
	output logic signed [tfp_pkg::OUT_W-1:0]    bin_z,
	output logic signed [tfp_pkg::OUT_W-1:0]    nrm_x,
	output logic signed [tfp_pkg::OUT_W-1:0]    nrm_y,
	output logic signed [tfp_pkg::OUT_W-1:0]    nrm_z,
	output logic                                degenerate
);
	localparam int OUT_W = tfp_pkg::OUT_W;
	localparam int DW = COORD_WIDTH + 1;
	localparam int CW = FRAC_BITS + 2;
	localparam int LU = tfp_pkg::unit_lat(FRAC_BITS);
	localparam int CL = tfp_pkg::CROSS_LAT;
	localparam int SC = 2 * LU + 2;
	localparam int DEPTH = SC + CL + 1;

	typedef logic signed [CW-1:0] comp_t;
	typedef logic signed [DW-1:0] diff_t;
	typedef logic signed [CW:0]   sum_t;

	logic              en;
	logic [DEPTH:1]    vld_s;

	diff_t             d1_s1 [3];
	diff_t             d3_s1 [3];
	comp_t             u_c [3];
	comp_t             v_c [3];
	comp_t             t_c [3];
	comp_t             n_c [3];
	comp_t             b_c [3];
	logic              za_c, zb_c, zc_c;
	sum_t              sum_s2 [3];

	comp_t             n_dly_q [LU-3][3];
	logic [LU:0]       dab_dly_q;
	comp_t             n4_q [CL][3];
	comp_t             t4_q [CL][3];
	logic [CL-1:0]     deg4_q;

	assign en = !(vld_s[DEPTH] && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_s[DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DEPTH-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1[0] <= DW'(p1_x) - DW'(p2_x);
			d1_s1[1] <= DW'(p1_y) - DW'(p2_y);
			d1_s1[2] <= DW'(p1_z) - DW'(p2_z);
			d3_s1[0] <= DW'(p3_x) - DW'(p2_x);
			d3_s1[1] <= DW'(p3_y) - DW'(p2_y);
			d3_s1[2] <= DW'(p3_z) - DW'(p2_z);
		end
	end

	tfp_unit3 #(.IN_W(DW), .FRAC(FRAC_BITS)) u_unit_u (
		.clk  (clk),
		.en   (en),
		.vec  (d1_s1),
		.uvec (u_c),
		.zero (za_c)
	);

	tfp_unit3 #(.IN_W(DW), .FRAC(FRAC_BITS)) u_unit_v (
		.clk  (clk),
		.en   (en),
		.vec  (d3_s1),
		.uvec (v_c),
		.zero (zb_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sum_s2[i] <= (CW+1)'(u_c[i]) + (CW+1)'(v_c[i]);
			end
		end
	end

	tfp_unit3 #(.IN_W(CW + 1), .FRAC(FRAC_BITS)) u_unit_t (
		.clk  (clk),
		.en   (en),
		.vec  (sum_s2),
		.uvec (t_c),
		.zero (zc_c)
	);

	tfp_cross #(.FRAC(FRAC_BITS)) u_cross_n (
		.clk (clk),
		.en  (en),
		.a   (u_c),
		.b   (v_c),
		.o   (n_c)
	);

	// normal and edge flags wait here for the tangent
	always_ff @(posedge clk) begin
		if (en) begin
			n_dly_q[0] <= n_c;
			for (int k = 1; k < LU - 3; k++) begin
				n_dly_q[k] <= n_dly_q[k-1];
			end
			dab_dly_q <= {dab_dly_q[LU-1:0], za_c | zb_c};
		end
	end

	tfp_cross #(.FRAC(FRAC_BITS)) u_cross_b (
		.clk (clk),
		.en  (en),
		.a   (n_dly_q[LU-4]),
		.b   (t_c),
		.o   (b_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			n4_q[0] <= n_dly_q[LU-4];
			t4_q[0] <= t_c;
			for (int k = 1; k < CL; k++) begin
				n4_q[k] <= n4_q[k-1];
				t4_q[k] <= t4_q[k-1];
			end
			deg4_q <= {deg4_q[CL-2:0], dab_dly_q[LU] | zc_c};
		end
	end

	// degenerate transactions carry all-zero vectors
	always_ff @(posedge clk) begin
		if (en) begin
			degenerate <= deg4_q[CL-1];
			tan_x <= deg4_q[CL-1] ? '0 : OUT_W'(t4_q[CL-1][0]);
			tan_y <= deg4_q[CL-1] ? '0 : OUT_W'(t4_q[CL-1][1]);
			tan_z <= deg4_q[CL-1] ? '0 : OUT_W'(t4_q[CL-1][2]);
			bin_x <= deg4_q[CL-1] ? '0 : OUT_W'(b_c[0]);
			bin_y <= deg4_q[CL-1] ? '0 : OUT_W'(b_c[1]);
			bin_z <= deg4_q[CL-1] ? '0 : OUT_W'(b_c[2]);
			nrm_x <= deg4_q[CL-1] ? '0 : OUT_W'(n4_q[CL-1][0]);
			nrm_y <= deg4_q[CL-1] ? '0 : OUT_W'(n4_q[CL-1][1]);
			nrm_z <= deg4_q[CL-1] ? '0 : OUT_W'(n4_q[CL-1][2]);
		end
	end

endmodule
`default_nettype wire

// File: src/tfp_check.sv
`default_nettype none
`include "tangent_frame_from_three_points_defines.svh"
module tfp_check #(
	parameter int FRAC_BITS = 14
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic signed [15:0] tan_x,
	input logic signed [15:0] tan_y,
	input logic signed [15:0] tan_z,
	input logic signed [15:0] bin_x,
	input logic signed [15:0] bin_y,
	input logic signed [15:0] bin_z,
	input logic signed [15:0] nrm_x,
	input logic signed [15:0] nrm_y,
	input logic signed [15:0] nrm_z,
	input logic        degenerate
);
	localparam int ONE = 1 << FRAC_BITS;
	localparam logic FITS = (FRAC_BITS <= 14);

	`TFP_ASSERT_NOW(a_deg_zero, clk, arst_n, out_valid && degenerate, tan_x == 0 && tan_y == 0 && tan_z == 0 && bin_x == 0 && bin_y == 0 && bin_z == 0 && nrm_x == 0 && nrm_y == 0 && nrm_z == 0, "degenerate transaction with nonzero vector")
	`TFP_ASSERT_NOW(a_nrm_range, clk, arst_n, out_valid && !degenerate && FITS, nrm_x <= ONE && nrm_x >= -ONE && nrm_y <= ONE && nrm_y >= -ONE && nrm_z <= ONE && nrm_z >= -ONE, "normal component beyond unit range")
	`TFP_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without a held result")
	`TFP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(tan_x) && $stable(bin_y) && $stable(nrm_z) && $stable(degenerate), "stalled result changed")

endmodule

bind tangent_frame_from_three_points tfp_check #(.FRAC_BITS(FRAC_BITS)) u_tfp_check (.*);
`default_nettype wire

// File: tb/frame_checker.sv
`timescale 1ns / 1ps
module frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] tan_x, tan_y, tan_z, bin_x, bin_y, bin_z, nrm_x, nrm_y, nrm_z,
	input  logic        degenerate,
	output int          fail_count,
	output int          pending,
	output int          frames_seen,
	output int          degen_seen
);
	localparam int FRAC = 14;
	typedef logic signed [63:0] s64_t;
	typedef struct packed {
		logic [15:0] tx, ty, tz, bx, by, bz, nx, ny, nz;
		logic        dg;
	} frame_t;

	frame_t frame_q[$];

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic make_unit(input s64_t c0, c1, c2, output s64_t o0, o1, o2);
		logic [63:0] mag [3];
		logic        neg [3];
		s64_t        c [3];
		logic [63:0] m, sum, len, q;
		int          bl;
		c[0] = c0; c[1] = c1; c[2] = c2;
		m = 0; sum = 0; bl = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = c[i] < 0;
			mag[i] = neg[i] ? -c[i] : c[i];
			if (mag[i] > m) m = mag[i];
		end
		o0 = 0; o1 = 0; o2 = 0;
		if (m == 0) return 1'b0;
		while (bl < 64 && (m >> bl) != 0) bl++;
		for (int i = 0; i < 3; i++) begin
			if (bl > 24) mag[i] = mag[i] >> (bl - 24);
			else mag[i] = mag[i] << (24 - bl);
			sum += mag[i] * mag[i];
		end
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << FRAC) + (len >> 1)) / len;
			c[i] = neg[i] ? -s64_t'(q) : s64_t'(q);
		end
		o0 = c[0]; o1 = c[1]; o2 = c[2];
		return 1'b1;
	endfunction

	function automatic s64_t round_clamp(input s64_t x);
		logic [63:0] mag;
		s64_t        r;
		mag = (x < 0) ? -x : x;
		r = s64_t'((mag + (64'd1 << (FRAC - 1))) >> FRAC);
		if (x < 0) r = -r;
		if (r > (64'sd1 << FRAC)) r = 64'sd1 << FRAC;
		if (r < -(64'sd1 << FRAC)) r = -(64'sd1 << FRAC);
		return r;
	endfunction

	function automatic frame_t tangent_frame(input logic [31:0] a[9]);
		s64_t   p [9];
		s64_t   ux, uy, uz, vx, vy, vz, tx, ty, tz, nx, ny, nz, bx, by, bz;
		logic   ok;
		frame_t f;
		for (int i = 0; i < 9; i++) p[i] = s64_t'($signed(a[i]));
		f = '0;
		ok = make_unit(p[0] - p[3], p[1] - p[4], p[2] - p[5], ux, uy, uz);
		if (ok) ok = make_unit(p[6] - p[3], p[7] - p[4], p[8] - p[5], vx, vy, vz);
		if (ok) ok = make_unit(ux + vx, uy + vy, uz + vz, tx, ty, tz);
		if (!ok) begin
			f.dg = 1'b1;
			return f;
		end
		nx = round_clamp(uy * vz - uz * vy);
		ny = round_clamp(uz * vx - ux * vz);
		nz = round_clamp(ux * vy - uy * vx);
		bx = round_clamp(ny * tz - nz * ty);
		by = round_clamp(nz * tx - nx * tz);
		bz = round_clamp(nx * ty - ny * tx);
		f.tx = tx[15:0]; f.ty = ty[15:0]; f.tz = tz[15:0];
		f.bx = bx[15:0]; f.by = by[15:0]; f.bz = bz[15:0];
		f.nx = nx[15:0]; f.ny = ny[15:0]; f.nz = nz[15:0];
		return f;
	endfunction

	assign pending = frame_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] pts [9];
		frame_t      got, want;
		if (!arst_n) begin
			fail_count <= 0;
			frames_seen <= 0;
			degen_seen <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				pts = '{p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z};
				frame_q.push_back(tangent_frame(pts));
			end
			if (out_valid && !out_stall) begin
				got = '{tan_x, tan_y, tan_z, bin_x, bin_y, bin_z, nrm_x, nrm_y, nrm_z,
					degenerate};
				frames_seen <= frames_seen + 1;
				if (degenerate) degen_seen <= degen_seen + 1;
				if (frame_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected result transaction %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = frame_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch t=%0t expected %h actual %h", $time, want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        out_stall = 0;
	logic        in_stall, out_valid, degenerate;
	logic [31:0] pt [9];
	logic [15:0] tan_x, tan_y, tan_z, bin_x, bin_y, bin_z, nrm_x, nrm_y, nrm_z;
	int          fail_count, pending, frames_seen, degen_seen;
	int          send_idle = 0, recv_idle = 0;
	longint      cycles = 0;

	initial for (int i = 0; i < 9; i++) pt[i] = '0;

	always #6 clk = ~clk;

	tangent_frame_from_three_points u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.p1_x(pt[0]), .p1_y(pt[1]), .p1_z(pt[2]), .p2_x(pt[3]), .p2_y(pt[4]),
		.p2_z(pt[5]), .p3_x(pt[6]), .p3_y(pt[7]), .p3_z(pt[8]),
		.out_valid(out_valid), .out_stall(out_stall),
		.tan_x(tan_x), .tan_y(tan_y), .tan_z(tan_z), .bin_x(bin_x), .bin_y(bin_y),
		.bin_z(bin_z), .nrm_x(nrm_x), .nrm_y(nrm_y), .nrm_z(nrm_z),
		.degenerate(degenerate)
	);

	frame_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.p1_x(pt[0]), .p1_y(pt[1]), .p1_z(pt[2]), .p2_x(pt[3]), .p2_y(pt[4]),
		.p2_z(pt[5]), .p3_x(pt[6]), .p3_y(pt[7]), .p3_z(pt[8]),
		.out_valid(out_valid), .out_stall(out_stall),
		.tan_x(tan_x), .tan_y(tan_y), .tan_z(tan_z), .bin_x(bin_x), .bin_y(bin_y),
		.bin_z(bin_z), .nrm_x(nrm_x), .nrm_y(nrm_y), .nrm_z(nrm_z),
		.degenerate(degenerate), .fail_count(fail_count), .pending(pending),
		.frames_seen(frames_seen), .degen_seen(degen_seen)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("testbench failed");
			$finish;
		end
	end

	// receiver stalls at random
	always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle);

	function automatic logic [31:0] rand_coord(input int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(2000) - 1000;
			2: return 32'($urandom_range(20'hfffff, 0)) - 32'h00080000;
			default: return $urandom & 32'h0fffffff;
		endcase
	endfunction

	// hand one triangle to the block, with optional leading idle cycles
	task automatic send_tri(input logic [31:0] a[9]);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		for (int i = 0; i < 9; i++) pt[i] <= a[i];
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic random_phase(input int count);
		logic [31:0] a [9];
		int          mode, kind;
		for (int n = 0; n < count; n++) begin
			mode = $urandom_range(3);
			for (int i = 0; i < 9; i++) a[i] = rand_coord(mode);
			kind = $urandom_range(19);
			// collinear, repeated and mirrored points, and extreme coordinates
			if (kind == 0) for (int i = 0; i < 3; i++) a[i] = a[3 + i];
			if (kind == 1) for (int i = 0; i < 3; i++) a[6 + i] = a[3 + i];
			if (kind == 2) for (int i = 0; i < 3; i++) a[6 + i] = 2 * a[3 + i] - a[i];
			if (kind == 3) for (int i = 0; i < 3; i++) a[6 + i] = a[3 + i] + 3 * (a[i] - a[3 + i]);
			if (kind == 4) for (int i = 0; i < 9; i++) a[i] = $urandom_range(1) ? 32'h80000000 : 32'h7fffffff;
			send_tri(a);
		end
	endtask

	task automatic directed_phase;
		logic [31:0] a [9];
		logic [31:0] ext [4];
		ext = '{32'h80000000, 32'h7fffffff, 32'h00000000, 32'hffffffff};
		a = '{32'h10000, 0, 0, 0, 0, 0, 0, 32'h10000, 0};
		send_tri(a);
		a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_tri(a);
		a = '{5, 5, 5, 5, 5, 5, 7, 0, 1};
		send_tri(a);
		a = '{1, 2, 3, 0, 0, 0, 0, 0, 0};
		send_tri(a);
		a = '{32'h10000, 0, 0, 0, 0, 0, 32'hffff0000, 0, 0};
		send_tri(a);
		a = '{1, 1, 1, 0, 0, 0, 3, 3, 3};
		send_tri(a);
		a = '{32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 32'h80000000, 32'h7fffffff, 0};
		send_tri(a);
		a = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000};
		send_tri(a);
		a = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
		send_tri(a);
		for (int k = 0; k < 12; k++) begin
			for (int i = 0; i < 9; i++) a[i] = ext[$urandom_range(3)];
			send_tri(a);
		end
		a = '{1, 0, 0, 0, 0, 0, 0, 1, 0};
		send_tri(a);
		a = '{32'hffffffff, 0, 0, 0, 0, 0, 1, 0, 0};
		send_tri(a);
	endtask

	initial begin
		int waited;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 35;
		recv_idle = 66;
		directed_phase;
		random_phase(180);
		send_idle = 66;
		recv_idle = 35;
		random_phase(180);
		send_idle = 0;
		recv_idle = 0;
		random_phase(190);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		waited = 0;
		while (waited < 150) begin
			@(posedge clk);
			waited++;
		end
		$display("frames checked: %0d, degenerate among them: %0d", frames_seen, degen_seen);
		$display("covered extremes, coincident, opposite and collinear edges under stalls");
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule

// File: sim.f
+incdir+src
src/tfp_pkg.sv
src/tfp_unit3.sv
src/tfp_cross.sv
src/tangent_frame_from_three_points.sv
src/tfp_check.sv
tb/frame_checker.sv
tb/testbench.sv
